>>> hdl/bsac_pkg.sv
// Shared types and constants for the brake sensor average check.
package bsac_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SUM_W       = 16;
   localparam int LEVEL_W     = 10;
   localparam int CAL_W       = 12;
   localparam int WINDOW_DEF  = 10;
   localparam int QUEUE_DEPTH = 2;

   // Numerator of the level division: (avg - low) * 1000 stays below 2**22.
   localparam int NUM_W = 22;

   localparam logic [SAMPLE_W-1:0] ADC_FULL    = 12'd4095;
   localparam logic [LEVEL_W-1:0]  LEVEL_FULL  = 10'd1000;
   localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR = 10'd50;

   localparam logic [CAL_W-1:0] LOW_CAL_RST  = 12'd350;
   localparam logic [CAL_W-1:0] HIGH_CAL_RST = 12'd3000;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CAL_W;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CAL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CAL = 1'd1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_ch1;
      logic [SAMPLE_W-1:0] sample_ch2;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_ch1;
      logic [SAMPLE_W-1:0] avg_ch2;
      logic [LEVEL_W-1:0]  brake_level;
      logic                fault;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_ch1;
      logic [SAMPLE_W-1:0] avg_ch2;
   } avg_pair_type;

   typedef struct packed {
      logic [CAL_W-1:0] low;
      logic [CAL_W-1:0] high;
   } cal_type;

   typedef struct packed {
      logic         valid;
      avg_pair_type data;
   } queue_port_type;

endpackage

>>> hdl/bsac_front.sv
// Front end: sliding windows, running sums and the averages handed to the queue.
module bsac_front #(
   parameter int WINDOW = bsac_pkg::WINDOW_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bsac_pkg::req_type       req,
   output bsac_pkg::queue_port_type push,
   input  logic                    q_full
);

   localparam int SW     = bsac_pkg::SAMPLE_W;
   localparam int UW     = bsac_pkg::SUM_W;
   localparam int SHIFT  = UW + $clog2(WINDOW);
   localparam int RECIP_W = UW + 2;
   // Rounded-up reciprocal; exact floor for every sum below 2**SUM_W.
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);
   localparam int PROD_W = UW + RECIP_W;

   logic [SW-1:0] win1_ff [WINDOW];
   logic [SW-1:0] win2_ff [WINDOW];
   logic [UW-1:0] sum1_ff, sum1_in;
   logic [UW-1:0] sum2_ff, sum2_in;
   logic          primed_ff, primed_in;
   logic          pend_ff, pend_in;
   logic          accept;
   logic [PROD_W-1:0] prod1, prod2;

   assign req_stall = pend_ff & q_full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (primed_ff) begin
         sum1_in = sum1_ff - UW'(win1_ff[0]) + UW'(req.sample_ch1);
         sum2_in = sum2_ff - UW'(win2_ff[0]) + UW'(req.sample_ch2);
      end else begin
         sum1_in = UW'(req.sample_ch1) * UW'(WINDOW);
         sum2_in = UW'(req.sample_ch2) * UW'(WINDOW);
      end
      primed_in = primed_ff | accept;
      pend_in   = accept | (pend_ff & q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         pend_ff   <= 1'b0;
         sum1_ff   <= '0;
         sum2_ff   <= '0;
      end else begin
         primed_ff <= primed_in;
         pend_ff   <= pend_in;
         if (accept) begin
            sum1_ff <= sum1_in;
            sum2_ff <= sum2_in;
         end
      end
   end

   // The first beat after reset fills every entry of both windows.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            win1_ff[i] <= primed_ff ? win1_ff[i+1] : req.sample_ch1;
            win2_ff[i] <= primed_ff ? win2_ff[i+1] : req.sample_ch2;
         end
         win1_ff[WINDOW-1] <= req.sample_ch1;
         win2_ff[WINDOW-1] <= req.sample_ch2;
      end
   end

   assign prod1 = PROD_W'(sum1_ff) * PROD_W'(RECIP);
   assign prod2 = PROD_W'(sum2_ff) * PROD_W'(RECIP);

   assign push.valid        = pend_ff & ~q_full;
   assign push.data.avg_ch1 = prod1[SHIFT +: SW];
   assign push.data.avg_ch2 = prod2[SHIFT +: SW];

endmodule

>>> hdl/bsac_queue.sv
// Short queue of average pairs between the front end and the level unit.
module bsac_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  bsac_pkg::queue_port_type push,
   output logic                     full,
   input  logic                     pop,
   output bsac_pkg::queue_port_type head
);

   localparam int DEPTH = bsac_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   bsac_pkg::avg_pair_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push.valid) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.data;
      end
   end

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.data  = mem_ff[rd_ff];

endmodule

>>> hdl/bsac_back.sv
// Level unit: fault check, calibration scaling with a bit-serial divider, result register.
module bsac_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bsac_pkg::queue_port_type head,
   output logic                     pop,
   input  bsac_pkg::cal_type        cal,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bsac_pkg::rsp_type        rsp
);

   localparam int SW  = bsac_pkg::SAMPLE_W;
   localparam int NW  = bsac_pkg::NUM_W;
   localparam int LW  = bsac_pkg::LEVEL_W;
   localparam int CW  = $clog2(NW);
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [SW-1:0]  avg1_ff, avg2_ff;
   logic           fault_ff;
   logic           zero_ff;
   logic [SW-1:0]  diff_ff;
   logic [SW-1:0]  den_ff;
   logic [NW-1:0]  num_ff, num_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff;
   logic           rsp_valid_ff;
   bsac_pkg::rsp_type rsp_ff;
   logic           fault_now;
   logic           zero_now;
   logic [SW:0]    shifted;
   logic           ge;
   logic           load_out;
   logic [LW-1:0]  level;

   assign fault_now = (head.data.avg_ch2 == '0) || (head.data.avg_ch2 >= bsac_pkg::ADC_FULL);
   assign zero_now  = fault_now || (cal.high <= cal.low) || (head.data.avg_ch2 <= cal.low);

   // One restoring step: the next numerator bit enters the remainder, a quotient
   // bit enters at the bottom of the numerator register.
   assign shifted = {rem_ff, num_ff[NW-1]};
   assign ge      = (shifted >= {1'b0, den_ff});
   always_comb begin
      rem_in = ge ? SW'(shifted - {1'b0, den_ff}) : shifted[SW-1:0];
      num_in = {num_ff[NW-2:0], ge};
   end

   always_comb begin
      if (zero_ff) begin
         level = '0;
      end else if (num_ff > NW'(bsac_pkg::LEVEL_FULL)) begin
         level = bsac_pkg::LEVEL_FULL;
      end else if (num_ff < NW'(bsac_pkg::LEVEL_FLOOR)) begin
         level = '0;
      end else begin
         level = num_ff[LW-1:0];
      end
   end

   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign pop      = (state_ff == S_IDLE) && head.valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (head.valid) state_in = S_MUL;
         S_MUL:  state_in = zero_ff ? S_DONE : S_DIV;
         S_DIV:  if (cnt_ff == LAST_STEP) state_in = S_DONE;
         S_DONE: if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         avg1_ff  <= head.data.avg_ch1;
         avg2_ff  <= head.data.avg_ch2;
         fault_ff <= fault_now;
         zero_ff  <= zero_now;
         diff_ff  <= head.data.avg_ch2 - cal.low;
         den_ff   <= cal.high - cal.low;
      end
      if (state_ff == S_MUL) begin
         num_ff <= NW'(diff_ff) * NW'(bsac_pkg::LEVEL_FULL);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == S_DIV) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (load_out) begin
         rsp_ff.avg_ch1     <= avg1_ff;
         rsp_ff.avg_ch2     <= avg2_ff;
         rsp_ff.brake_level <= level;
         rsp_ff.fault       <= fault_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> hdl/brake_sensor_average_check.sv
// Top level of the brake sensor average and range-fault check.
//
//   channel   ports                          carries
//   request   req_valid, req_stall, req      one pair of 12-bit sensor samples
//   response  rsp_valid, rsp_stall, rsp      averages, brake level, fault bit
//   csr       csr_we, csr_index, csr_wdata   low and high channel-2 calibration
//
// The front end takes a sample beat every cycle while the queue has room.
// Each item passes through the level unit as pop, multiply, 22 divider steps and
// result load; a fault or a level forced to zero skips the divider steps.
// The one-bit-per-cycle divider sets the sustained rate.
// Reset is synchronous; the windows need no reset since the first beat fills them.
// A stalled response holds the level unit, and the queue then stalls the requests.
module brake_sensor_average_check #(
   parameter int WINDOW = bsac_pkg::WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bsac_pkg::req_type                   req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bsac_pkg::rsp_type                   rsp,
   input  logic                                csr_we,
   input  logic [bsac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsac_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bsac_pkg::cal_type        cal_ff;
   bsac_pkg::queue_port_type push;
   bsac_pkg::queue_port_type head;
   logic                     q_full;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.low  <= bsac_pkg::LOW_CAL_RST;
         cal_ff.high <= bsac_pkg::HIGH_CAL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bsac_pkg::CSR_LOW_CAL:  cal_ff.low  <= csr_wdata[bsac_pkg::CAL_W-1:0];
            bsac_pkg::CSR_HIGH_CAL: cal_ff.high <= csr_wdata[bsac_pkg::CAL_W-1:0];
            default: ;
         endcase
      end
   end

   bsac_front #(
      .WINDOW(WINDOW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .push      (push),
      .q_full    (q_full)
   );

   bsac_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   bsac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .cal       (cal_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
